// ===== src/infix_to_postfix_converter_core_assert.svh =====
// Assertion macros used by the checker file of the infix-to-postfix core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ITP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle rule");

`endif

// ===== src/itp_pkg.sv =====
// Package of the infix-to-postfix core: operator codes, error codes, the
// stack command type and the character decode functions. Depends on nothing.
package itp_pkg;

   typedef logic [2:0] code_type;
   typedef logic [2:0] err_type;

   // Operator codes held on the stack.
   localparam code_type OP_OPEN  = 3'd0;
   localparam code_type OP_PLUS  = 3'd1;
   localparam code_type OP_MINUS = 3'd2;
   localparam code_type OP_MUL   = 3'd3;
   localparam code_type OP_DIV   = 3'd4;
   localparam code_type OP_POW   = 3'd5;

   // Error codes of a result.
   localparam err_type ERR_NONE  = 3'd0;
   localparam err_type ERR_BAD   = 3'd1;
   localparam err_type ERR_CLOSE = 3'd2;
   localparam err_type ERR_OPEN  = 3'd3;
   localparam err_type ERR_OVF   = 3'd4;

   // ASCII characters the converter recognizes.
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_POW   = 8'h5E;

   // Command handed to all cells of the stack together.
   typedef struct packed {
      logic     push;
      logic     pop;
      code_type code;
   } stack_cmd_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
             (c == CH_DIV) || (c == CH_POW);
   endfunction

   function automatic code_type op_code_of(input logic [7:0] c);
      code_type r;
      unique case (c)
         CH_PLUS:  r = OP_PLUS;
         CH_MINUS: r = OP_MINUS;
         CH_MUL:   r = OP_MUL;
         CH_DIV:   r = OP_DIV;
         CH_POW:   r = OP_POW;
         default:  r = OP_OPEN;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_char(input code_type code);
      logic [7:0] r;
      unique case (code)
         OP_OPEN:  r = CH_OPEN;
         OP_PLUS:  r = CH_PLUS;
         OP_MINUS: r = CH_MINUS;
         OP_MUL:   r = CH_MUL;
         OP_DIV:   r = CH_DIV;
         OP_POW:   r = CH_POW;
         default:  r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] op_prec(input code_type code);
      logic [1:0] r;
      unique case (code)
         OP_PLUS, OP_MINUS: r = 2'd1;
         OP_MUL, OP_DIV:    r = 2'd2;
         OP_POW:            r = 2'd3;
         default:           r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/infix_to_postfix_converter_core.sv =====
// Top level of the infix-to-postfix converter: control sequencer, fill count,
// output register. Depends on itp_pkg and itp_stack.
//
//  Channel | Dir | Handshake           | Payload
//  req     | in  | req_tvalid/tready   | tdata[7:0] in_char, tlast end_of_expr
//  rsp     | out | rsp_tvalid/tready   | tdata[7:0] out_char, tlast last_of_expr,
//          |     |                     | tuser[0] char_valid, tuser[3:1] error_code
//
// An item is taken while idle, then worked on one step per cycle: a letter,
// '(' or a plain push takes one step, and every operator popped from the stack
// adds one step, since the stack cell row moves by one entry per step.
// Every step, with or without a result, waits while the output register is
// full and not being taken. Reset is synchronous; it clears the fill count, the
// discard flag and the handshakes, and the stack cells need no clearing.
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [3:0] rsp_tuser,   // [0] char_valid, [3:1] error_code
   output logic       rsp_tlast
);
   import itp_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             disc_ff, disc_in;
   logic [7:0]       char_ff, char_in;
   logic             end_ff, end_in;
   logic             out_vld_ff, out_vld_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_cv_ff, out_cv_in;
   logic             out_last_ff, out_last_in;
   err_type          out_err_ff, out_err_in;

   stack_cmd_type cmd;
   code_type      top_code;
   code_type      item_code;
   logic          out_free;
   logic          stack_full;
   logic          stack_empty;
   logic          emit;
   logic [7:0]    e_char;
   logic          e_cv;
   logic          e_last;
   err_type       e_err;

   itp_stack #(.DEPTH(STACK_DEPTH)) u_stack (
      .clock    (clock),
      .cmd      (cmd),
      .top_code (top_code)
   );

   assign out_free    = !out_vld_ff || rsp_tready;
   assign stack_full  = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (cnt_ff == '0);
   assign item_code   = op_code_of(char_ff);
   assign req_tready  = (state_ff == S_IDLE);

   // Sequencer: one decision per cycle on the held request, while the output register is free.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      disc_in  = disc_ff;
      char_in  = char_ff;
      end_in   = end_ff;
      cmd.push = 1'b0;
      cmd.pop  = 1'b0;
      cmd.code = item_code;
      emit     = 1'b0;
      e_char   = 8'h00;
      e_cv     = 1'b0;
      e_last   = 1'b0;
      e_err    = ERR_NONE;
      if (state_ff == S_IDLE) begin
         if (req_tvalid) begin
            char_in  = req_tdata;
            end_in   = req_tlast;
            state_in = S_WORK;
         end
      end else if (out_free) begin
         priority if (disc_ff) begin
            if (end_ff) begin
               disc_in = 1'b0;
            end
            state_in = S_IDLE;
         end else if (end_ff) begin
            // Flush the stack, then close the expression; a leftover '(' closes it with an error.
            priority if (stack_empty) begin
               emit     = 1'b1;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end else if (top_code == OP_OPEN) begin
               emit     = 1'b1;
               e_last   = 1'b1;
               e_err    = ERR_OPEN;
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               emit    = 1'b1;
               e_char  = op_char(top_code);
               e_cv    = 1'b1;
               cmd.pop = 1'b1;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
         end else if (is_letter(char_ff)) begin
            emit     = 1'b1;
            e_char   = char_ff;
            e_cv     = 1'b1;
            state_in = S_IDLE;
         end else if (char_ff == CH_OPEN) begin
            if (stack_full) begin
               emit    = 1'b1;
               e_last  = 1'b1;
               e_err   = ERR_OVF;
               cnt_in  = '0;
               disc_in = 1'b1;
            end else begin
               cmd.push = 1'b1;
               cmd.code = OP_OPEN;
               cnt_in   = cnt_ff + CNT_W'(1);
            end
            state_in = S_IDLE;
         end else if (char_ff == CH_CLOSE) begin
            // Pop down to the matching open parenthesis; an empty stack is an error.
            priority if (stack_empty) begin
               emit     = 1'b1;
               e_last   = 1'b1;
               e_err    = ERR_CLOSE;
               disc_in  = 1'b1;
               state_in = S_IDLE;
            end else if (top_code != OP_OPEN) begin
               emit    = 1'b1;
               e_char  = op_char(top_code);
               e_cv    = 1'b1;
               cmd.pop = 1'b1;
               cnt_in  = cnt_ff - CNT_W'(1);
            end else begin
               cmd.pop  = 1'b1;
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end else if (is_operator(char_ff)) begin
            // Pop operators of equal or higher rank, then push this one.
            priority if (!stack_empty && (top_code != OP_OPEN) &&
                         (op_prec(item_code) <= op_prec(top_code))) begin
               emit    = 1'b1;
               e_char  = op_char(top_code);
               e_cv    = 1'b1;
               cmd.pop = 1'b1;
               cnt_in  = cnt_ff - CNT_W'(1);
            end else if (stack_full) begin
               emit     = 1'b1;
               e_last   = 1'b1;
               e_err    = ERR_OVF;
               cnt_in   = '0;
               disc_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.push = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_IDLE;
            end
         end else begin
            emit     = 1'b1;
            e_last   = 1'b1;
            e_err    = ERR_BAD;
            disc_in  = 1'b1;
            state_in = S_IDLE;
         end
      end
   end

   // Output register: loaded by a result step, cleared when taken.
   always_comb begin
      out_char_in = out_char_ff;
      out_cv_in   = out_cv_ff;
      out_last_in = out_last_ff;
      out_err_in  = out_err_ff;
      if (emit) begin
         out_vld_in  = 1'b1;
         out_char_in = e_char;
         out_cv_in   = e_cv;
         out_last_in = e_last;
         out_err_in  = e_err;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         disc_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         disc_ff    <= disc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      end_ff      <= end_in;
      out_char_ff <= out_char_in;
      out_cv_ff   <= out_cv_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = {out_err_ff, out_cv_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/itp_stack_cell.sv =====
// One cell of the shifting operator stack: holds one operator code.
// Depends on itp_pkg for the command and code types.
module itp_stack_cell (
   input  logic                  clock,
   input  itp_pkg::stack_cmd_type cmd,
   input  itp_pkg::code_type     from_above,
   input  itp_pkg::code_type     from_below,
   output itp_pkg::code_type     code
);
   import itp_pkg::*;

   code_type code_ff;
   code_type code_in;

   // A push takes the neighbor above, a pop the neighbor below.
   always_comb begin
      priority if (cmd.push) begin
         code_in = from_above;
      end else if (cmd.pop) begin
         code_in = from_below;
      end else begin
         code_in = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

// ===== src/itp_stack.sv =====
// Operator stack built as a row of shifting cells; cell 0 is the top.
// Depends on itp_pkg and itp_stack_cell.
module itp_stack #(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  itp_pkg::stack_cmd_type cmd,
   output itp_pkg::code_type     top_code
);
   import itp_pkg::*;

   code_type cell_q [DEPTH];

   // Each cell passes its code one step down on a push and up on a pop.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      code_type above;
      code_type below;
      if (i == 0) begin : g_top
         assign above = cmd.code;
      end else begin : g_mid
         assign above = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_bot
         assign below = OP_OPEN;
      end else begin : g_rest
         assign below = cell_q[i+1];
      end
      itp_stack_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .from_above (above),
         .from_below (below),
         .code       (cell_q[i])
      );
   end

   assign top_code = cell_q[0];

endmodule

// ===== src/itp_core_checker.sv =====
// Port-level checker of the infix-to-postfix core and its bind statement.
// Depends on infix_to_postfix_converter_core_assert.svh and itp_pkg.
`include "infix_to_postfix_converter_core_assert.svh"

module itp_core_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser,
   input logic       rsp_tlast
);
   import itp_pkg::*;

   // A stalled result holds its contents.
   `ITP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // An error result closes the expression and carries no character.
   `ITP_ASSERT_NOW(a_err_last, clock, reset, rsp_tvalid && (rsp_tuser[3:1] != ERR_NONE), rsp_tlast && !rsp_tuser[0] && (rsp_tdata == 8'h00))

   // A character result never closes the expression.
   `ITP_ASSERT_NOW(a_char_not_last, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tlast && (rsp_tuser[3:1] == ERR_NONE))

   // The core works on one request at a time.
   `ITP_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // Only the known error codes appear.
   `ITP_ASSERT_NOW(a_err_range, clock, reset, rsp_tvalid, rsp_tuser[3:1] <= ERR_OVF)

endmodule

bind infix_to_postfix_converter_core itp_core_checker u_itp_core_checker (.*);
